[rtl/ramt_pkg.sv]
// Shared types and constants for the range-add minimum tree.
package ramt_pkg;

  localparam int POS_W   = 11;
  localparam int DELTA_W = 16;
  localparam int VAL_W   = 32;

  localparam logic [POS_W-1:0] POS_RESET = 11'd1024;

  // Partial nodes on one root-to-leaf path, with an 11-bit position count.
  localparam int STK_D  = 12;
  localparam int STK_AW = $clog2(STK_D);
  localparam int SP_W   = $clog2(STK_D + 1);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_START,
    OP_ENTER,
    OP_LOAD,
    OP_PUSHL,
    OP_PUSHR,
    OP_DESCEND,
    OP_TURN,
    OP_POP,
    OP_COMB1,
    OP_COMB2,
    OP_COMB3,
    OP_ROOT,
    OP_EMIT
  } ramt_op_e;

  typedef struct packed {
    ramt_op_e op;
  } ramt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic k_oob;
    logic push_needed;
    logic partial;
    logic sp_empty;
    logic top_right;
    logic out_free;
  } ramt_sts_t;

endpackage

[rtl/ramt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ramt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ramt_ctrl.sv]
// Controller state machine sequencing the tree walk.
module ramt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ramt_pkg::ramt_sts_t sts_i,
  output ramt_pkg::ramt_cmd_t cmd_o
);
  import ramt_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ENTER = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_PUSHL = 4'd4;
  localparam logic [3:0] S_PUSHR = 4'd5;
  localparam logic [3:0] S_DESC  = 4'd6;
  localparam logic [3:0] S_RET   = 4'd7;
  localparam logic [3:0] S_COMB1 = 4'd8;
  localparam logic [3:0] S_COMB2 = 4'd9;
  localparam logic [3:0] S_COMB3 = 4'd10;
  localparam logic [3:0] S_ROOT  = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          state_d  = S_ENTER;
        end
      end
      S_ENTER: begin
        cmd_o.op = OP_ENTER;
        state_d  = sts_i.k_oob ? S_RET : S_LOAD;
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD;
        if (sts_i.push_needed) state_d = S_PUSHL;
        else if (sts_i.partial) state_d = S_DESC;
        else state_d = S_RET;
      end
      S_PUSHL: begin
        cmd_o.op = OP_PUSHL;
        state_d  = S_PUSHR;
      end
      S_PUSHR: begin
        cmd_o.op = OP_PUSHR;
        state_d  = sts_i.partial ? S_DESC : S_RET;
      end
      S_DESC: begin
        cmd_o.op = OP_DESCEND;
        state_d  = S_ENTER;
      end
      S_RET: begin
        if (sts_i.sp_empty) begin
          state_d = S_ROOT;
        end else if (sts_i.top_right) begin
          cmd_o.op = OP_POP;
          state_d  = S_COMB1;
        end else begin
          cmd_o.op = OP_TURN;
          state_d  = S_ENTER;
        end
      end
      S_COMB1: begin
        cmd_o.op = OP_COMB1;
        state_d  = S_COMB2;
      end
      S_COMB2: begin
        cmd_o.op = OP_COMB2;
        state_d  = S_COMB3;
      end
      S_COMB3: begin
        cmd_o.op = OP_COMB3;
        state_d  = S_RET;
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_clear_only_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clear pass re-entered");

  a_start_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_START) |-> (state_q == S_IDLE) && in_valid_i)
    else $error("transaction started outside idle");

  a_emit_leaves_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && sts_i.out_free) |=> (state_q == S_IDLE))
    else $error("result not handed over");

endmodule

[rtl/ramt_dp.sv]
// Datapath: node stores, walk frame, return stack, config and output register.
module ramt_dp #(
  parameter int LEAVES = 1024,
  parameter int NODES  = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ramt_pkg::ramt_cmd_t               cmd_i,
  output ramt_pkg::ramt_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic [ramt_pkg::POS_W-1:0]        cfg_wdata_i,
  input  logic [ramt_pkg::POS_W-1:0]        range_low_i,
  input  logic [ramt_pkg::POS_W-1:0]        range_high_i,
  input  logic signed [ramt_pkg::DELTA_W-1:0] delta_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ramt_pkg::VAL_W-1:0] global_min_o
);
  import ramt_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int KW = ($clog2(NODES) + 1 > POS_W + 3) ? $clog2(NODES) + 1 : POS_W + 3;

  // config
  logic [POS_W-1:0] pos_count_q, pos_count_d;

  // walk frame and item
  logic [KW-1:0]    k_q, k_d;
  logic [POS_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [POS_W-1:0] ql_q, ql_d, qh_q, qh_d;
  logic [VAL_W-1:0] d_q, d_d, t_q, t_d, a_q, a_d;
  logic [AW-1:0]    clr_q, clr_d;

  // return stack
  logic [KW-1:0]    stk_k_q  [STK_D];
  logic [POS_W-1:0] stk_lo_q [STK_D];
  logic [POS_W-1:0] stk_hi_q [STK_D];
  logic             stk_r_q  [STK_D];
  logic [SP_W-1:0]  sp_q, sp_d;
  logic [SP_W-1:0]  tix;
  logic             push_en, turn_en;

  // output
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] res_q;
  logic             res_en, out_free;

  // node stores
  logic             mn_we, pd_we;
  logic [AW-1:0]    mn_waddr, mn_raddr, pd_waddr, pd_raddr;
  logic [VAL_W-1:0] mn_wdata, mn_rdata, pd_wdata, pd_rdata;

  // derived
  logic [AW-1:0]    k_addr, c_addr, c1_addr;
  logic [KW-1:0]    c, c1, tk, tc1;
  logic             k_oob, c_in, c1_in, leaf, disj, cov, partial;
  logic [VAL_W-1:0] t_new, b_val;
  logic [POS_W:0]   sum, tsum;
  logic [POS_W-1:0] mid, tlo, thi, tmid1, top;

  ramt_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (mn_we),
    .waddr_i (mn_waddr),
    .wdata_i (mn_wdata),
    .raddr_i (mn_raddr),
    .rdata_o (mn_rdata)
  );

  ramt_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pd_we),
    .waddr_i (pd_waddr),
    .wdata_i (pd_wdata),
    .raddr_i (pd_raddr),
    .rdata_o (pd_rdata)
  );

  assign c       = {k_q[KW-2:0], 1'b0};
  assign c1      = {k_q[KW-2:0], 1'b1};
  assign k_addr  = k_q[AW-1:0];
  assign c_addr  = c[AW-1:0];
  assign c1_addr = c1[AW-1:0];
  assign k_oob   = (k_q >= KW'(NODES));
  assign c_in    = (c < KW'(NODES));
  assign c1_in   = (c1 < KW'(NODES));
  assign leaf    = (lo_q == hi_q);
  assign disj    = (hi_q < ql_q) || (lo_q > qh_q);
  assign cov     = (lo_q >= ql_q) && (hi_q <= qh_q);
  assign partial = !disj && !cov;
  assign t_new   = pd_rdata + (cov ? d_q : '0);
  assign b_val   = c1_in ? mn_rdata : '0;
  assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = sum[POS_W:1];

  assign tix   = sp_q - SP_W'(1);
  assign tk    = stk_k_q[tix[STK_AW-1:0]];
  assign tlo   = stk_lo_q[tix[STK_AW-1:0]];
  assign thi   = stk_hi_q[tix[STK_AW-1:0]];
  assign tc1   = {tk[KW-2:0], 1'b1};
  assign tsum  = {1'b0, tlo} + {1'b0, thi};
  assign tmid1 = tsum[POS_W:1] + POS_W'(1);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    top = pos_count_q;
    if (pos_count_q == '0) begin
      top = POS_W'(1);
    end else if (32'(pos_count_q) > 32'(LEAVES)) begin
      top = POS_W'(LEAVES);
    end
  end

  always_comb begin
    pos_count_d = cfg_we_i ? cfg_wdata_i : pos_count_q;
    k_d      = k_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ql_d     = ql_q;
    qh_d     = qh_q;
    d_d      = d_q;
    t_d      = t_q;
    a_d      = a_q;
    clr_d    = clr_q;
    sp_d     = sp_q;
    push_en  = 1'b0;
    turn_en  = 1'b0;
    res_en   = 1'b0;
    mn_we    = 1'b0;
    mn_waddr = k_addr;
    mn_wdata = '0;
    mn_raddr = '0;
    pd_we    = 1'b0;
    pd_waddr = k_addr;
    pd_wdata = '0;
    pd_raddr = '0;
    case (cmd_i.op)
      OP_NONE: begin
      end
      OP_CLEAR: begin
        mn_we    = 1'b1;
        mn_waddr = clr_q;
        pd_we    = 1'b1;
        pd_waddr = clr_q;
        clr_d    = clr_q + AW'(1);
      end
      OP_START: begin
        k_d  = KW'(1);
        lo_d = POS_W'(1);
        hi_d = top;
        ql_d = range_low_i;
        qh_d = range_high_i;
        d_d  = VAL_W'(delta_i);
        sp_d = '0;
      end
      OP_ENTER: begin
        mn_raddr = k_addr;
        pd_raddr = k_addr;
      end
      OP_LOAD: begin
        mn_we    = 1'b1;
        mn_wdata = mn_rdata + t_new;
        pd_we    = 1'b1;
        t_d      = t_new;
        pd_raddr = c_addr;
      end
      OP_PUSHL: begin
        pd_we    = c_in;
        pd_waddr = c_addr;
        pd_wdata = pd_rdata + t_q;
        pd_raddr = c1_addr;
      end
      OP_PUSHR: begin
        pd_we    = c1_in;
        pd_waddr = c1_addr;
        pd_wdata = pd_rdata + t_q;
      end
      OP_DESCEND: begin
        push_en = 1'b1;
        sp_d    = sp_q + SP_W'(1);
        k_d     = c;
        hi_d    = mid;
      end
      OP_TURN: begin
        turn_en = 1'b1;
        k_d     = tc1;
        lo_d    = tmid1;
        hi_d    = thi;
      end
      OP_POP: begin
        sp_d = tix;
        k_d  = tk;
        lo_d = tlo;
        hi_d = thi;
      end
      OP_COMB1: begin
        mn_raddr = c_addr;
      end
      OP_COMB2: begin
        a_d      = c_in ? mn_rdata : '0;
        mn_raddr = c1_addr;
      end
      OP_COMB3: begin
        mn_we    = 1'b1;
        mn_wdata = ($signed(a_q) <= $signed(b_val)) ? a_q : b_val;
      end
      OP_ROOT: begin
        mn_raddr = AW'(1);
      end
      OP_EMIT: begin
        mn_raddr = AW'(1);
        res_en   = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_count_q <= POS_RESET;
      clr_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_count_q <= pos_count_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q  <= k_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    ql_q <= ql_d;
    qh_q <= qh_d;
    d_q  <= d_d;
    t_q  <= t_d;
    a_q  <= a_d;
    if (res_en) begin
      res_q <= mn_rdata;
    end
    if (push_en) begin
      stk_k_q[sp_q[STK_AW-1:0]]  <= k_q;
      stk_lo_q[sp_q[STK_AW-1:0]] <= lo_q;
      stk_hi_q[sp_q[STK_AW-1:0]] <= hi_q;
      stk_r_q[sp_q[STK_AW-1:0]]  <= 1'b0;
    end
    if (turn_en) begin
      stk_r_q[tix[STK_AW-1:0]] <= 1'b1;
    end
  end

  assign sts_o.clr_last    = (clr_q == AW'(NODES - 1));
  assign sts_o.k_oob       = k_oob;
  assign sts_o.push_needed = !leaf && (t_new != '0);
  assign sts_o.partial     = partial;
  assign sts_o.sp_empty    = (sp_q == '0);
  assign sts_o.top_right   = stk_r_q[tix[STK_AW-1:0]];
  assign sts_o.out_free    = out_free;

  assign out_valid_o  = out_valid_q;
  assign global_min_o = res_q;

  a_stack_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DESCEND) |-> (sp_q < SP_W'(STK_D)))
    else $error("return stack overflow");

  a_stack_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP || cmd_i.op == OP_TURN) |-> (sp_q != '0))
    else $error("return stack underflow");

  a_pend_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pd_we && cmd_i.op != OP_CLEAR) |-> (pd_raddr != pd_waddr))
    else $error("pending store read and write at one address");

  a_min_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mn_we && cmd_i.op != OP_CLEAR) |-> (mn_raddr != mn_waddr))
    else $error("minimum store read and write at one address");

endmodule

[rtl/range_add_min_tree_unit.sv]
// Top level: lazy segment tree with range add and global minimum.
// After reset the block zeroes all NODES entries of both node stores and takes no transaction
// meanwhile (configuration writes are taken). Each transaction adds delta to positions
// range_low..range_high of 1..position_count (a count of 0 acts as 1, one above LEAVES as
// LEAVES) and returns one result, the minimum over all positions. The walk visits nodes one
// at a time through single-port-read node stores: a visited node is read, updated and
// returned from, a nonzero pending add is moved to its children after the update, and a
// node split by the range is descended into and later combined (its two children read,
// their minimum written). After the walk the root is read and loaded into the output
// register, and the next transaction is taken in the idle state. The output register holds a
// result while the next transaction is being taken; a result still stalled there when the
// next one is ready holds that one at the hand-over.
module range_add_min_tree_unit #(
  parameter int LEAVES = 1024,
  parameter int NODES  = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ramt_pkg::POS_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ramt_pkg::POS_W-1:0]        range_low_i,
  input  logic [ramt_pkg::POS_W-1:0]        range_high_i,
  input  logic signed [ramt_pkg::DELTA_W-1:0] delta_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ramt_pkg::VAL_W-1:0] global_min_o
);
  import ramt_pkg::*;

  ramt_cmd_t cmd;
  ramt_sts_t sts;

  ramt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ramt_dp #(
    .LEAVES (LEAVES),
    .NODES  (NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .delta_i      (delta_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .global_min_o (global_min_o)
  );

endmodule
